### hw/rtl/sorted_priority_queue_core_defines.svh
// Assertion macros used by the priority queue core.
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// Check that a condition implies another one in the same cycle.
`define SPQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies another one in the next cycle.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/spq_pkg.sv
// Types and codes shared by the priority queue RTL.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Request kind codes
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] in_priority;
    logic signed [31:0] in_value;
  } spq_in_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               ok;
    logic               now_empty;
  } spq_out_t;

  typedef struct packed {
    logic signed [15:0] prio;
    logic signed [31:0] value;
  } spq_entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t new_entry;
  } spq_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/spq_cell.sv
// One slot of the sorted register chain.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire spq_pkg::spq_cmd_t    cmd_i,
  input  wire logic                 occupied_i,
  input  wire logic                 left_keep_i,
  input  wire spq_pkg::spq_entry_t  left_entry_i,
  input  wire spq_pkg::spq_entry_t  right_entry_i,
  output spq_pkg::spq_entry_t       entry_o,
  output logic                      keep_o
);
  import spq_pkg::*;

  spq_entry_t entry_q, entry_d;

  // Stay in place when holding an entry that goes ahead of the new one
  assign keep_o = occupied_i && (entry_q.prio <= cmd_i.new_entry.prio);

  // Pick hold, take new, shift from left or shift from right
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.enq) begin
      if (keep_o) begin
        entry_d = entry_q;
      end else if (left_keep_i) begin
        entry_d = cmd_i.new_entry;
      end else begin
        entry_d = left_entry_i;
      end
    end else if (cmd_i.deq) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

### hw/rtl/sorted_priority_queue_core.sv
// Top level of the sorted priority queue.
// A bounded priority queue of DEPTH entries held in a chain of register cells
// sorted by ascending signed priority, equal priorities served first in, first
// out. Each request is an enqueue or a dequeue and yields exactly one result.
// Every cell compares the incoming priority against its own entry in parallel,
// so a request is processed in the cycle it is accepted and its result appears
// in the output register on the next cycle; a new request is taken every
// cycle while the result side keeps up. An enqueue into a full queue and a
// dequeue from an empty queue fail with ok low and leave the queue unchanged.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_priority_queue_core_defines.svh"

module sorted_priority_queue_core #(
  parameter int DEPTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire spq_pkg::spq_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output spq_pkg::spq_out_t     out_data_o
);
  import spq_pkg::*;

  localparam int COUNT_W = $clog2(DEPTH + 1);

  logic [COUNT_W-1:0] count_q, count_d;
  logic               out_valid_q;
  spq_out_t           out_q;

  logic       in_acc;
  logic       full;
  logic       empty;
  logic       enq_ok;
  logic       deq_ok;
  spq_cmd_t   cmd;

  logic [DEPTH-1:0] occupied;
  logic [DEPTH-1:0] keep;
  spq_entry_t       entries [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign full       = (count_q == COUNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign enq_ok     = in_acc && (in_data_i.kind == KIND_ENQ) && !full;
  assign deq_ok     = in_acc && (in_data_i.kind == KIND_DEQ) && !empty;

  // Broadcast the command to the chain
  assign cmd.enq             = enq_ok;
  assign cmd.deq             = deq_ok;
  assign cmd.new_entry.prio  = in_data_i.in_priority;
  assign cmd.new_entry.value = in_data_i.in_value;

  // Build the cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       left_keep;
    spq_entry_t left_entry;
    spq_entry_t right_entry;

    assign occupied[i] = (count_q > COUNT_W'(i));

    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_entry = cmd.new_entry;
    end else begin : g_body
      assign left_keep  = keep[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .occupied_i    (occupied[i]),
      .left_keep_i   (left_keep),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (entries[i]),
      .keep_o        (keep[i])
    );
  end

  // Advance the fill count
  always_comb begin
    count_d = count_q;
    if (enq_ok) begin
      count_d = count_q + COUNT_W'(1);
    end else if (deq_ok) begin
      count_d = count_q - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q.out_value <= deq_ok ? entries[0].value : '0;
      out_q.ok        <= enq_ok || deq_ok;
      out_q.now_empty <= (count_d == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks on the chain and the fill count
  `SPQ_ASSERT_ALWAYS(a_count_bound, count_q <= COUNT_W'(DEPTH))
  `SPQ_ASSERT_NEXT(a_enq_grows, enq_ok, count_q == $past(count_q) + COUNT_W'(1))
  `SPQ_ASSERT_NEXT(a_empty_flag, in_acc, out_q.now_empty == (count_q == '0))
  `SPQ_ASSERT_SAME(a_head_sorted, occupied[1], entries[0].prio <= entries[1].prio)

endmodule

`default_nettype wire
